// ===== sv/ptwa_pkg.sv =====
// ----------------------------------------------------------------------------
// ptwa_pkg
// Shared types and constants of the pulse template waveform accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package ptwa_pkg;

  // input function codes
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [1:0] SHAPE_NONE = 2'd3;

  // register indexes
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [2:0] REG_FIRST_SAMPLE  = 3'd1;
  localparam logic [2:0] REG_FIXED_DELAY   = 3'd2;
  localparam logic [2:0] REG_GRID_START    = 3'd3;
  localparam logic [2:0] REG_GRID_SHIFT    = 3'd4;
  localparam logic [2:0] REG_PEAK_SINGLE   = 3'd5;
  localparam logic [2:0] REG_PEAK_XTALK    = 3'd6;
  localparam logic [2:0] REG_PEAK_SHARING  = 3'd7;

  localparam logic signed [24:0] SAMPLE_MAX = 25'sd8388607;
  localparam logic signed [24:0] SAMPLE_MIN = -25'sd8388608;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_ADD,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [1:0]         shape;
    logic [9:0]         index;
    logic signed [15:0] point_value;
    logic [23:0]        pulse_time;
    logic [15:0]        pulse_gain;
  } item_t;

  typedef struct packed {
    logic [15:0]        sample_period;
    logic [10:0]        first_sample_time;
    logic [15:0]        fixed_delay;
    logic signed [23:0] grid_start;
    logic [3:0]         grid_step_shift;
    logic [2:0][23:0]   peak_time;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/ptwa_front.sv =====
// ----------------------------------------------------------------------------
// ptwa_front
// Accepts items, decodes them into operations and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwa_front import ptwa_pkg::*; #(
  parameter int TEMPLATE_POINTS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [1:0]         in_func,
  input  wire logic [1:0]         in_shape_sel,
  input  wire logic [9:0]         in_index,
  input  wire logic signed [15:0] in_point_value,
  input  wire logic [23:0]        in_pulse_time,
  input  wire logic [15:0]        in_pulse_gain,
  input  wire logic               init_busy,
  input  wire logic               pop,
  output      logic               q_valid,
  output      item_t              q_item
);

  item_t      cls;
  item_t      slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  always_comb begin
    cls.shape       = in_shape_sel;
    cls.index       = in_index;
    cls.point_value = in_point_value;
    cls.pulse_time  = in_pulse_time;
    cls.pulse_gain  = in_pulse_gain;
    case (in_func)
      FUNC_LOAD: begin
        cls.op = (in_shape_sel != SHAPE_NONE && 32'(in_index) < TEMPLATE_POINTS)
                 ? OP_LOAD : OP_NOP;
      end
      FUNC_ADD:   cls.op = (in_shape_sel != SHAPE_NONE) ? OP_ADD : OP_NOP;
      FUNC_CLEAR: cls.op = OP_CLEAR;
      FUNC_READ:  cls.op = OP_READ;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign busy    = (cnt_r == 2'd2) || init_busy;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== sv/ptwa_back.sv =====
// ----------------------------------------------------------------------------
// ptwa_back
// Executes queued operations on the waveform and template memories.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwa_back import ptwa_pkg::*; #(
  parameter int WAVE_POINTS     = 1024,
  parameter int TEMPLATE_POINTS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               q_valid,
  input  wire item_t              q_item,
  output      logic               pop,
  output      logic               init_busy,
  output      logic               out_valid,
  output      logic signed [23:0] out_sample_value
);

  localparam int WAW = $clog2(WAVE_POINTS);
  localparam int TAW = $clog2(3 * TEMPLATE_POINTS);
  localparam int UW  = ((WAW + 16 > 26) ? WAW + 16 : 26) + 2;
  localparam int PW  = 26;
  localparam logic [WAW-1:0] LAST = WAW'(WAVE_POINTS - 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_PREP,
    ST_ADD,
    ST_DRAIN,
    ST_READ
  } state_t;

  state_t                 state_r;
  logic [WAW-1:0]         cnt_r;
  logic signed [UW-1:0]   u_r;
  logic signed [PW-1:0]   part_r;
  logic [1:0]             shape_r;
  logic [15:0]            gain_r;
  logic                   rd_oor_r;
  logic                   out_valid_r;
  logic signed [23:0]     out_value_r;

  logic signed [15:0]     tmem [3 * TEMPLATE_POINTS];
  logic signed [23:0]     wmem [WAVE_POINTS];
  logic signed [15:0]     y0_r, y1_r;
  logic signed [23:0]     wrd_r;

  // pipeline
  logic                   v1_r, in1_r, v2_r, v3_r, v4_r, v5_r;
  logic [14:0]            f1_r;
  logic [WAW-1:0]         i1_r, i2_r, i3_r, i4_r, i5_r;
  logic signed [23:0]     w2_r, w3_r, w4_r, w5_r;
  logic signed [15:0]     y0_2_r;
  logic signed [32:0]     p2_r;
  logic signed [31:0]     interp3_r;
  logic signed [48:0]     acc4_r;
  logic signed [17:0]     c5_r;

  logic [3:0]             sh;
  logic [31:0]            u32, k32, k1_32, span32, f32, ta0_32, ta1_32;
  logic                   in0;
  logic [TAW-1:0]         ta0, ta1;
  logic [31:0]            idx32, tw32;
  logic [WAW-1:0]         raddr, waddr;
  logic                   we, clearing, twe;
  logic signed [23:0]     wdata;
  logic signed [24:0]     sum;
  logic signed [23:0]     sat;
  logic signed [PW-1:0]   part_nxt;
  logic signed [48:0]     rnd;

  assign sh = cfg.grid_step_shift;

  // template address of the current sample
  always_comb begin
    u32    = 32'($unsigned(u_r));
    span32 = 32'(TEMPLATE_POINTS - 1) << sh;
    in0    = !u_r[UW-1] && (u32 <= span32);
    k32    = u32 >> sh;
    f32    = u32 & ((32'd1 << sh) - 32'd1);
    k1_32  = (k32 == 32'(TEMPLATE_POINTS - 1)) ? k32 : k32 + 32'd1;
    ta0_32 = in0 ? 32'(shape_r) * 32'(TEMPLATE_POINTS) + k32 : 32'd0;
    ta1_32 = in0 ? 32'(shape_r) * 32'(TEMPLATE_POINTS) + k1_32 : 32'd0;
    ta0    = ta0_32[TAW-1:0];
    ta1    = ta1_32[TAW-1:0];
  end

  always_comb begin
    idx32 = 32'(q_item.index);
    tw32  = 32'(q_item.shape) * 32'(TEMPLATE_POINTS) + idx32;
    twe   = (state_r == ST_IDLE) && q_valid && (q_item.op == OP_LOAD);
    raddr = (state_r == ST_ADD) ? cnt_r : idx32[WAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (twe) begin
      tmem[tw32[TAW-1:0]] <= q_item.point_value;
    end
    y0_r <= tmem[ta0];
    y1_r <= tmem[ta1];
  end

  // saturated accumulate at the write stage
  always_comb begin
    sum = 25'(w5_r) + 25'(c5_r);
    if (sum > SAMPLE_MAX) begin
      sat = 24'(SAMPLE_MAX);
    end else if (sum < SAMPLE_MIN) begin
      sat = 24'(SAMPLE_MIN);
    end else begin
      sat = sum[23:0];
    end
    clearing = (state_r == ST_INIT) || (state_r == ST_CLEAR);
    we       = clearing || v5_r;
    waddr    = clearing ? cnt_r : i5_r;
    wdata    = clearing ? 24'sd0 : sat;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      wmem[waddr] <= wdata;
    end
    wrd_r <= wmem[raddr];
  end

  always_comb begin
    rnd = acc4_r + (49'sd1 <<< (5'd15 + 5'(sh)));
  end

  always_ff @(posedge clk) begin
    f1_r      <= f32[14:0];
    i1_r      <= cnt_r;
    i2_r      <= i1_r;
    w2_r      <= wrd_r;
    y0_2_r    <= y0_r;
    p2_r      <= 33'(17'(y1_r) - 17'(y0_r)) * 33'($signed({1'b0, f1_r}));
    i3_r      <= i2_r;
    w3_r      <= w2_r;
    interp3_r <= 32'((33'(y0_2_r) <<< sh) + p2_r);
    i4_r      <= i3_r;
    w4_r      <= w3_r;
    acc4_r    <= 49'(interp3_r) * 49'($signed({1'b0, gain_r}));
    i5_r      <= i4_r;
    w5_r      <= w4_r;
    c5_r      <= 18'(rnd >>> (5'd16 + 5'(sh)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      in1_r <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
    end else begin
      v1_r  <= (state_r == ST_ADD);
      in1_r <= in0;
      v2_r  <= v1_r && in1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
    end
  end

  assign part_nxt = PW'(cfg.first_sample_time) - PW'(q_item.pulse_time)
                  - PW'(cfg.fixed_delay);

  assign pop       = (state_r == ST_IDLE) && q_valid;
  assign init_busy = (state_r == ST_INIT);
  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_READ);
      out_value_r <= rd_oor_r ? 24'sd0 : wrd_r;
      case (state_r)
        ST_INIT, ST_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            case (q_item.op)
              OP_CLEAR: begin
                cnt_r   <= '0;
                state_r <= ST_CLEAR;
              end
              OP_READ: begin
                rd_oor_r <= !(idx32 < 32'(WAVE_POINTS));
                state_r  <= ST_READ;
              end
              OP_ADD: begin
                shape_r <= q_item.shape;
                gain_r  <= q_item.pulse_gain;
                part_r  <= part_nxt;
                state_r <= ST_PREP;
              end
              default: ;
            endcase
          end
        end
        ST_PREP: begin
          u_r     <= UW'(part_r) + UW'(cfg.peak_time[shape_r]) - UW'(cfg.grid_start);
          cnt_r   <= '0;
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          u_r   <= u_r + UW'(cfg.sample_period);
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!(v1_r || v2_r || v3_r || v4_r || v5_r)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_READ: state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/pulse_template_waveform_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// pulse_template_waveform_accumulator_unit
// Waveform store that accumulates pulses interpolated from three templates.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. func selects
// load template point, add pulse, clear waveform or read sample. Items go
// into a two-entry queue and run one at a time in order.
// Only a read gives a result: out_valid pulses for one cycle with
// out_sample_value, registered out of the read state that follows the
// pop of the read from the queue.
// An add pulse sweeps every waveform sample once through a read-modify-write
// pipeline on the single-write waveform memory. Reset clears the waveform
// with a pass over every sample, during which busy stays high.
// Configuration must be written only while no item is in flight; the block
// itself does not enforce this.
// Template memory contents are undefined until loaded.
// The receiver cannot stall: each result must be taken in its cycle.
// Registers sit on the APB port at byte address 4*index.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_template_waveform_accumulator_unit import ptwa_pkg::*; #(
  parameter int WAVE_POINTS     = 1024,
  parameter int TEMPLATE_POINTS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [1:0]         in_func,
  input  wire logic [1:0]         in_shape_sel,
  input  wire logic [9:0]         in_index,
  input  wire logic signed [15:0] in_point_value,
  input  wire logic [23:0]        in_pulse_time,
  input  wire logic [15:0]        in_pulse_gain,
  output      logic               out_valid,
  output      logic signed [23:0] out_sample_value,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  cfg_t  cfg_r;
  logic  wr;
  logic  init_busy, pop, q_valid;
  item_t q_item;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_period     <= 16'd256;
      cfg_r.first_sample_time <= 11'd0;
      cfg_r.fixed_delay       <= 16'd2560;
      cfg_r.grid_start        <= 24'sd0;
      cfg_r.grid_step_shift   <= 4'd8;
      cfg_r.peak_time         <= '0;
    end else if (wr) begin
      case (paddr[4:2])
        REG_SAMPLE_PERIOD: cfg_r.sample_period     <= pwdata[15:0];
        REG_FIRST_SAMPLE:  cfg_r.first_sample_time <= pwdata[10:0];
        REG_FIXED_DELAY:   cfg_r.fixed_delay       <= pwdata[15:0];
        REG_GRID_START:    cfg_r.grid_start        <= pwdata[23:0];
        REG_GRID_SHIFT:    cfg_r.grid_step_shift   <= pwdata[3:0];
        REG_PEAK_SINGLE:   cfg_r.peak_time[0]      <= pwdata[23:0];
        REG_PEAK_XTALK:    cfg_r.peak_time[1]      <= pwdata[23:0];
        REG_PEAK_SHARING:  cfg_r.peak_time[2]      <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SAMPLE_PERIOD: prdata = 32'(cfg_r.sample_period);
      REG_FIRST_SAMPLE:  prdata = 32'(cfg_r.first_sample_time);
      REG_FIXED_DELAY:   prdata = 32'(cfg_r.fixed_delay);
      REG_GRID_START:    prdata = 32'($unsigned(cfg_r.grid_start));
      REG_GRID_SHIFT:    prdata = 32'(cfg_r.grid_step_shift);
      REG_PEAK_SINGLE:   prdata = 32'(cfg_r.peak_time[0]);
      REG_PEAK_XTALK:    prdata = 32'(cfg_r.peak_time[1]);
      REG_PEAK_SHARING:  prdata = 32'(cfg_r.peak_time[2]);
      default:           prdata = 32'd0;
    endcase
  end

  ptwa_front #(
    .TEMPLATE_POINTS(TEMPLATE_POINTS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_shape_sel  (in_shape_sel),
    .in_index      (in_index),
    .in_point_value(in_point_value),
    .in_pulse_time (in_pulse_time),
    .in_pulse_gain (in_pulse_gain),
    .init_busy     (init_busy),
    .pop           (pop),
    .q_valid       (q_valid),
    .q_item        (q_item)
  );

  ptwa_back #(
    .WAVE_POINTS    (WAVE_POINTS),
    .TEMPLATE_POINTS(TEMPLATE_POINTS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .pop             (pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_sample_value(out_sample_value)
  );

endmodule

`default_nettype wire
